[hdl/cisa_pkg.sv]
// Shared types, codes and constants of the cycle id slot allocator.
package cisa_pkg;

  // Default table depth
  localparam int MAX_SLOTS_DEF = 16;

  // Field widths
  localparam int REL_W    = 32;
  localparam int DB_W     = 32;
  localparam int CYCLE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CYCLE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT   = 2'd1;

  // Register reset values
  localparam logic [CYCLE_W-1:0] MAX_CYCLE_ID_RST = 16'hFFFF;
  localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RST   = 5'd16;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DUP  = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  // One table entry as stored in the slot memory
  typedef struct packed {
    logic [REL_W-1:0]   rel;
    logic [DB_W-1:0]    db;
    logic [CYCLE_W-1:0] cycle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/cisa_req_if.sv]
// Request channel: relation key, valid/ready handshake.
interface cisa_req_if;
  logic                          valid;
  logic                          ready;
  logic [cisa_pkg::REL_W-1:0]    rel_id;
  logic [cisa_pkg::DB_W-1:0]     db_id;

  modport source (output valid, output rel_id, output db_id, input ready);
  modport sink   (input valid, input rel_id, input db_id, output ready);
endinterface

[hdl/cisa_rsp_if.sv]
// Response channel: assigned cycle id and status, valid/ready handshake.
interface cisa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cisa_pkg::CYCLE_W-1:0]  cycle_id;
  cisa_pkg::status_t             status;

  modport source (output valid, output cycle_id, output status, input ready);
  modport sink   (input valid, input cycle_id, input status, output ready);
endinterface

[hdl/cycle_id_slot_allocator_core.sv]
// Top level of the cycle id slot allocator: configuration registers, slot memory, sequencer.
// Each start request advances the cycle counter, then looks for its (rel_id, db_id) key in
// the filled slots and either answers duplicate (1), full (2), or appends the key and
// returns the new cycle id with status ok (0); cycle_id reads zero on an error. A request
// is answered after its key is compared with the filled slots in order; a duplicate found
// ends the scan early, and an empty table skips the scan. The slot memory has one read
// port and is read one slot per cycle. One request is in progress at a time; the next one
// is taken while the previous response still waits on its ready. The table starts empty
// after reset, with no clearing pass. Write max_cycle_id (index 0) and slot_limit (index 1)
// only while idle.
module cycle_id_slot_allocator_core #(
  parameter int MAX_SLOTS = cisa_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  cisa_req_if.sink                         req,
  cisa_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [cisa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cisa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  logic [cisa_pkg::CYCLE_W-1:0] max_cycle_id;
  logic [cisa_pkg::LIMIT_W-1:0] slot_limit;
  logic [CNT_W-1:0]             usable_slots;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  cisa_pkg::entry_t             ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  cisa_pkg::entry_t             ram_rdata;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cycle_id <= cisa_pkg::MAX_CYCLE_ID_RST;
      slot_limit   <= cisa_pkg::SLOT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cisa_pkg::REG_MAX_CYCLE_ID: max_cycle_id <= cfg_wdata[cisa_pkg::CYCLE_W-1:0];
        cisa_pkg::REG_SLOT_LIMIT:   slot_limit   <= cfg_wdata[cisa_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the limit to the table depth
  always_comb begin
    if (32'(slot_limit) < 32'(MAX_SLOTS)) begin
      usable_slots = CNT_W'(slot_limit);
    end else begin
      usable_slots = CNT_W'(MAX_SLOTS);
    end
  end

  cisa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .rsp          (rsp),
    .max_cycle_id (max_cycle_id),
    .usable_slots (usable_slots),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  cisa_ram #(
    .WIDTH  (cisa_pkg::ENTRY_W),
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (IDX_W)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[hdl/cisa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module cisa_ram #(
  parameter int WIDTH  = cisa_pkg::ENTRY_W,
  parameter int DEPTH  = cisa_pkg::MAX_SLOTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/cisa_ctrl.sv]
// Request sequencer: counter advance, slot scan, append and response register.
module cisa_ctrl #(
  parameter int MAX_SLOTS = cisa_pkg::MAX_SLOTS_DEF,
  parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  cisa_req_if.sink                      req,
  cisa_rsp_if.source                    rsp,
  input  logic [cisa_pkg::CYCLE_W-1:0]  max_cycle_id,
  input  logic [CNT_W-1:0]              usable_slots,
  output logic                          ram_we,
  output logic [IDX_W-1:0]              ram_waddr,
  output cisa_pkg::entry_t              ram_wdata,
  output logic [IDX_W-1:0]              ram_raddr,
  input  cisa_pkg::entry_t              ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                         state;
  logic [cisa_pkg::CYCLE_W-1:0]   cycle_counter;
  logic [CNT_W-1:0]               entry_count;
  logic [IDX_W-1:0]               cmp_idx;
  logic                           dup;
  logic [cisa_pkg::REL_W-1:0]     key_rel;
  logic [cisa_pkg::DB_W-1:0]      key_db;
  logic                           rsp_valid;
  logic [cisa_pkg::CYCLE_W-1:0]   rsp_cycle_id;
  cisa_pkg::status_t              rsp_status;

  logic [cisa_pkg::CYCLE_W-1:0]   id_inc;
  logic [cisa_pkg::CYCLE_W-1:0]   cycle_counter_next;
  logic                           accept;
  logic                           out_free;
  logic                           match;
  logic                           last;
  cisa_pkg::status_t              status_next;

  // Advance the cycle counter, wrap to one on overflow or past the maximum
  assign id_inc = cycle_counter + cisa_pkg::CYCLE_W'(1);
  assign cycle_counter_next = (id_inc == '0 || id_inc > max_cycle_id)
                              ? cisa_pkg::CYCLE_W'(1) : id_inc;

  // Handshake
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;

  // Compare the slot read last cycle against the held key
  assign match = (ram_rdata.rel == key_rel) && (ram_rdata.db == key_db);
  assign last  = ((CNT_W'(cmp_idx) + CNT_W'(1)) == entry_count);

  // Read the next slot while scanning, slot zero otherwise
  assign ram_raddr = (state == S_SCAN) ? (cmp_idx + IDX_W'(1)) : '0;

  // Decide the outcome; duplicate wins over full
  always_comb begin
    if (dup) begin
      status_next = cisa_pkg::ST_DUP;
    end else if (entry_count >= usable_slots) begin
      status_next = cisa_pkg::ST_FULL;
    end else begin
      status_next = cisa_pkg::ST_OK;
    end
  end

  // Append the key in the next free slot
  assign ram_we          = (state == S_DONE) && out_free && (status_next == cisa_pkg::ST_OK);
  assign ram_waddr       = IDX_W'(entry_count);
  assign ram_wdata.rel   = key_rel;
  assign ram_wdata.db    = key_db;
  assign ram_wdata.cycle = cycle_counter;

  // Response outputs
  assign rsp.valid    = rsp_valid;
  assign rsp.cycle_id = rsp_cycle_id;
  assign rsp.status   = rsp_status;

  // Hold the key, scan slot by slot, then load the response beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cycle_counter <= '0;
      entry_count   <= '0;
      rsp_valid     <= 1'b0;
      dup           <= 1'b0;
      cmp_idx       <= '0;
    end else begin
      // Drop the response beat once taken; in S_DONE a new beat loads instead
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_rel       <= req.rel_id;
            key_db        <= req.db_id;
            cycle_counter <= cycle_counter_next;
            cmp_idx       <= '0;
            dup           <= 1'b0;
            state         <= (entry_count == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            dup   <= 1'b1;
            state <= S_DONE;
          end else if (last) begin
            state <= S_DONE;
          end else begin
            cmp_idx <= cmp_idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            rsp_status   <= status_next;
            rsp_cycle_id <= (status_next == cisa_pkg::ST_OK) ? cycle_counter : '0;
            if (status_next == cisa_pkg::ST_OK) begin
              entry_count <= entry_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
